/* rtl/hpid_pkg.sv */
// Shared widths, constants, register codes and types of the heading PID servo drive.
`default_nettype none

package hpid_pkg;

    localparam int HEAD_W  = 13;  // heading and target, 1/16 degree
    localparam int GAIN_W  = 16;  // Q8.8 gains
    localparam int KICK_W  = 9;   // kick and extra offsets, us
    localparam int DB_W    = 12;  // deadband
    localparam int ERR_W   = 13;  // wrapped error, signed
    localparam int DIFF_W  = 14;  // error difference, signed
    localparam int SUM_W   = 32;  // saturating integral
    localparam int PP_W    = 30;  // gain_prop * error
    localparam int PI_W    = 49;  // gain_integ * integral
    localparam int PD_W    = 31;  // gain_deriv * difference
    localparam int ACC_W   = 51;  // PID sum, 1/4096 us
    localparam int OFF_W   = ACC_W - 8;  // offset, 1/16 us
    localparam int PULSE_W = 11;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam int HALF_TURN   = 2880;
    localparam int FULL_TURN   = 5760;
    localparam int NEUTRAL_X16 = 24000;
    localparam int SPAN_X16    = 8000;   // pulse limits are neutral +- this

    // reset values of the registers
    localparam logic [HEAD_W-1:0] TARGET_RST   = 13'd1440;
    localparam logic [GAIN_W-1:0] GAIN_P_RST   = 16'd512;
    localparam logic [GAIN_W-1:0] GAIN_I_RST   = 16'd0;
    localparam logic [GAIN_W-1:0] GAIN_D_RST   = 16'd26;
    localparam logic [KICK_W-1:0] MIN_KICK_RST = 9'd60;
    localparam logic [KICK_W-1:0] FWD_XTRA_RST = 9'd30;
    localparam logic [DB_W-1:0]   DEADBAND_RST = 12'd16;

    typedef enum logic [2:0] {
        REG_TARGET   = 3'd0,
        REG_GAIN_P   = 3'd1,
        REG_GAIN_I   = 3'd2,
        REG_GAIN_D   = 3'd3,
        REG_MIN_KICK = 3'd4,
        REG_FWD_XTRA = 3'd5,
        REG_DEADBAND = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [KICK_W-1:0] min_kick;
        logic [KICK_W-1:0] fwd_extra;
        logic [DB_W-1:0]   deadband;
    } kick_cfg_t;

endpackage

`default_nettype wire

/* rtl/hpid_shape.sv */
// Minimum-kick override, pulse clamp and truncation to whole microseconds.
`default_nettype none

module hpid_shape
    import hpid_pkg::*;
(
    input  wire logic signed [OFF_W-1:0]   offset,
    input  wire logic signed [ERR_W-1:0]   err,
    input  wire kick_cfg_t                 kick_cfg,
    output logic             [PULSE_W-1:0] pulse_us
);

    localparam logic signed [OFF_W-1:0] SPAN    = OFF_W'(SPAN_X16);
    localparam logic signed [OFF_W-1:0] NEUTRAL = OFF_W'(NEUTRAL_X16);

    logic        [ERR_W-1:0]   mag_e;
    logic signed [OFF_W-1:0]   kick_lo_mag;
    logic signed [OFF_W-1:0]   kick_hi;
    logic                      near;
    logic signed [OFF_W-1:0]   off_k;
    logic signed [OFF_W-1:0]   off_c;
    logic signed [OFF_W-1:0]   pulse_x16;

    always_comb begin
        mag_e       = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        kick_lo_mag = $signed({{(OFF_W-KICK_W-4){1'b0}}, kick_cfg.min_kick, 4'b0});
        kick_hi     = $signed({{(OFF_W-KICK_W-5){1'b0}},
                               ({1'b0, kick_cfg.min_kick} + {1'b0, kick_cfg.fwd_extra}),
                               4'b0});
        near = (offset < kick_lo_mag) && (offset > -kick_lo_mag)
               && (mag_e > {1'b0, kick_cfg.deadband});

        if (near) begin
            off_k = (offset > 0) ? kick_hi : -kick_lo_mag;
        end else begin
            off_k = offset;
        end

        priority if (off_k < -SPAN) begin
            off_c = -SPAN;
        end else if (off_k > SPAN) begin
            off_c = SPAN;
        end else begin
            off_c = off_k;
        end

        pulse_x16 = NEUTRAL + off_c;
        pulse_us  = pulse_x16[PULSE_W+3:4];
    end

endmodule

`default_nettype wire

/* rtl/heading_pid_servo_drive.sv */
// Heading PID servo drive: APB registers, error/integral stage, PID pipeline, output.
//
//  port group   dir  role
//  s_*          in   heading sample beat (valid/ready)
//  m_*          out  pulse width and wrapped error beat (valid/ready)
//  p*           in   APB register port, pready tied high
//
// One beat per cycle sustained while m_ready stays high; five registers lie between input
// accept and result valid: input, error/integral, product, offset, output.
// Integral and last error update when a beat leaves the input register.
// Each stage holds when the one after it is full and stalled; bubbles collapse.
// aresetn is synchronous, active low; clears valids and state, loads register reset values.
`default_nettype none

module heading_pid_servo_drive
    import hpid_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [DATA_W-1:0]    pwdata,
    output logic      [DATA_W-1:0]    prdata,
    output logic                      pready,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [HEAD_W-1:0]    s_measured_heading,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [PULSE_W-1:0]   m_pulse_width_us,
    output logic signed [ERR_W-1:0]   m_wrapped_error
);

    // configuration
    logic [HEAD_W-1:0] target_reg;
    logic [GAIN_W-1:0] gain_p_reg;
    logic [GAIN_W-1:0] gain_i_reg;
    logic [GAIN_W-1:0] gain_d_reg;
    logic [KICK_W-1:0] min_kick_reg;
    logic [KICK_W-1:0] fwd_extra_reg;
    logic [DB_W-1:0]   deadband_reg;
    reg_idx_t          cfg_idx;
    logic              cfg_wr;

    // controller state
    logic signed [ERR_W-1:0] last_error_reg;
    logic signed [SUM_W-1:0] error_sum_reg;

    // pipeline
    logic                     v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic                     en1, en2, en3, en4, en5, adv1;
    logic [HEAD_W-1:0]        meas_reg;
    logic signed [ERR_W-1:0]  e_reg, e3_reg, e4_reg, out_err_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [DIFF_W-1:0] d_reg;
    logic signed [PP_W-1:0]   pp_reg;
    logic signed [PI_W-1:0]   pi_reg;
    logic signed [PD_W-1:0]   pd_reg;
    logic signed [OFF_W-1:0]  off_reg;
    logic [PULSE_W-1:0]       pulse_reg;

    logic signed [DIFF_W-1:0] raw_e;
    logic signed [DIFF_W-1:0] wrap1_e;
    logic signed [DIFF_W-1:0] wrap2_e;
    logic signed [ERR_W-1:0]  e_next;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [DIFF_W-1:0] d_next;
    logic signed [PP_W-1:0]   pp_next;
    logic signed [PI_W-1:0]   pi_next;
    logic signed [PD_W-1:0]   pd_next;
    logic signed [ACC_W-1:0]  acc_next;
    logic [PULSE_W-1:0]       pulse_next;
    kick_cfg_t                kick_cfg;

    // ---------------- APB ----------------
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= TARGET_RST;
            gain_p_reg    <= GAIN_P_RST;
            gain_i_reg    <= GAIN_I_RST;
            gain_d_reg    <= GAIN_D_RST;
            min_kick_reg  <= MIN_KICK_RST;
            fwd_extra_reg <= FWD_XTRA_RST;
            deadband_reg  <= DEADBAND_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TARGET:   target_reg    <= pwdata[HEAD_W-1:0];
                REG_GAIN_P:   gain_p_reg    <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:   gain_i_reg    <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:   gain_d_reg    <= pwdata[GAIN_W-1:0];
                REG_MIN_KICK: min_kick_reg  <= pwdata[KICK_W-1:0];
                REG_FWD_XTRA: fwd_extra_reg <= pwdata[KICK_W-1:0];
                REG_DEADBAND: deadband_reg  <= pwdata[DB_W-1:0];
                default: ;  // drop writes to unmapped addresses
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_TARGET:   prdata = DATA_W'(target_reg);
            REG_GAIN_P:   prdata = DATA_W'(gain_p_reg);
            REG_GAIN_I:   prdata = DATA_W'(gain_i_reg);
            REG_GAIN_D:   prdata = DATA_W'(gain_d_reg);
            REG_MIN_KICK: prdata = DATA_W'(min_kick_reg);
            REG_FWD_XTRA: prdata = DATA_W'(fwd_extra_reg);
            REG_DEADBAND: prdata = DATA_W'(deadband_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------- stage enables ----------------
    assign en5     = !out_valid_reg || m_ready;
    assign en4     = !v4_reg || en5;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign adv1    = v1_reg && en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en1) v1_reg        <= s_valid;
            if (en2) v2_reg        <= v1_reg;
            if (en3) v3_reg        <= v2_reg;
            if (en4) v4_reg        <= v3_reg;
            if (en5) out_valid_reg <= v4_reg;
        end
    end

    // ---------------- error, wrap, integral, difference ----------------
    always_comb begin
        raw_e   = $signed({1'b0, target_reg}) - $signed({1'b0, meas_reg});
        wrap1_e = (raw_e > DIFF_W'(HALF_TURN)) ? raw_e - DIFF_W'(FULL_TURN) : raw_e;
        wrap2_e = (wrap1_e < -DIFF_W'(HALF_TURN)) ? wrap1_e + DIFF_W'(FULL_TURN) : wrap1_e;
        e_next  = wrap2_e[ERR_W-1:0];

        sum_wide = {error_sum_reg[SUM_W-1], error_sum_reg}
                   + {{(SUM_W+1-ERR_W){e_next[ERR_W-1]}}, e_next};
        // saturate when the two top bits disagree
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_next = sum_wide[SUM_W-1:0];
        end

        d_next = DIFF_W'(e_next) - DIFF_W'(last_error_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_reg <= '0;
            error_sum_reg  <= '0;
        end else if (adv1) begin
            last_error_reg <= e_next;
            error_sum_reg  <= sum_next;
        end
    end

    // ---------------- products, offset ----------------
    always_comb begin
        pp_next  = $signed({1'b0, gain_p_reg}) * e_reg;
        pi_next  = $signed({1'b0, gain_i_reg}) * sum_reg;
        pd_next  = $signed({1'b0, gain_d_reg}) * d_reg;
        acc_next = ACC_W'(pp_reg) + ACC_W'(pi_reg) + ACC_W'(pd_reg);
    end

    assign kick_cfg = '{min_kick: min_kick_reg, fwd_extra: fwd_extra_reg,
                        deadband: deadband_reg};

    hpid_shape u_shape (
        .offset   (off_reg),
        .err      (e4_reg),
        .kick_cfg (kick_cfg),
        .pulse_us (pulse_next)
    );

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && en1) begin
            meas_reg <= s_measured_heading;
        end
        if (adv1) begin
            e_reg   <= e_next;
            sum_reg <= sum_next;
            d_reg   <= d_next;
        end
        if (v2_reg && en3) begin
            pp_reg <= pp_next;
            pi_reg <= pi_next;
            pd_reg <= pd_next;
            e3_reg <= e_reg;
        end
        if (v3_reg && en4) begin
            off_reg <= acc_next[ACC_W-1:8];  // arithmetic shift: floor
            e4_reg  <= e3_reg;
        end
        if (v4_reg && en5) begin
            pulse_reg   <= pulse_next;
            out_err_reg <= e4_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_pulse_width_us = pulse_reg;
    assign m_wrapped_error  = out_err_reg;

`ifndef SYNTH
    a_state_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        adv1 |=> (last_error_reg == e_reg) && (error_sum_reg == sum_reg))
        else $error("controller state out of step with error stage");

    a_pulse_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pulse_width_us >= 11'd1000) && (m_pulse_width_us <= 11'd2000))
        else $error("pulse width outside servo range");

    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_wrapped_error >= -13'sd2880) && (m_wrapped_error <= 13'sd2880))
        else $error("wrapped error outside half turn");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
`endif

endmodule

`default_nettype wire
